[hdl/hsd_pkg.sv]
// shared types and constants for the huffman string decoder
// no dependencies; imported by every module of the block

package hsd_pkg;

   localparam int NODE_IDX_BITS = 8;                  // node index and symbol width
   localparam int CHILD_BITS    = 9;                  // leaf flag plus index or symbol
   localparam int NODE_BITS     = 2 * CHILD_BITS;     // {child_one, child_zero}
   localparam int CHAR_BITS     = 8;                  // raw character width
   localparam int CNT_BITS      = 3;                  // bit counter inside one byte
   localparam int LEAF_BIT      = CHILD_BITS - 1;

   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = 2;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_BIT  = 1'b1;

   typedef struct packed {
      logic                     op;
      logic                     stream_bit;
      logic [NODE_IDX_BITS-1:0] node_addr;
      logic [CHILD_BITS-1:0]    child_zero;
      logic [CHILD_BITS-1:0]    child_one;
   } req_type;

   typedef struct packed {
      logic [CHAR_BITS-1:0] symbol;
      logic                 last_char;
      logic                 empty_string;
   } rsp_type;

   // classified item as it travels from the front to the back
   typedef struct packed {
      logic                     is_load;
      logic                     wr_ok;
      logic                     stream_bit;
      logic [NODE_IDX_BITS-1:0] node_addr;
      logic [NODE_BITS-1:0]     node_data;
   } cmd_type;

endpackage

[hdl/hsd_front.sv]
// front end: classifies each request into a command for the queue
// depends on hsd_pkg

module hsd_front
   import hsd_pkg::*;
#(
   parameter int NODE_DEPTH = 256
)(
   input  req_type req_data,
   output cmd_type cmd
);

   always_comb begin
      cmd            = '0;
      cmd.is_load    = (req_data.op == OP_LOAD);
      cmd.stream_bit = req_data.stream_bit;
      cmd.node_addr  = req_data.node_addr;
      cmd.node_data  = {req_data.child_one, req_data.child_zero};
      // loads beyond the table are dropped
      cmd.wr_ok      = ({1'b0, req_data.node_addr} < (NODE_IDX_BITS + 1)'(NODE_DEPTH));
   end

endmodule

[hdl/hsd_queue.sv]
// small command queue between front and back
// depends on hsd_pkg

module hsd_queue
   import hsd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   cmd_type                q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]     count_ff, count_in;
   logic                   do_push, do_pop;

   assign full      = (count_ff == (QPTR_BITS + 1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = q_mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
`endif

endmodule

[hdl/hsd_back.sv]
// back end: frame decoder, node table memory and result register
// depends on hsd_pkg

module hsd_back
   import hsd_pkg::*;
#(
   parameter int NODE_DEPTH  = 256,
   parameter int LENGTH_BITS = 8
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = (NODE_DEPTH > 1) ? $clog2(NODE_DEPTH) : 1;
   localparam logic [CNT_BITS-1:0] LEN_LAST  = CNT_BITS'(LENGTH_BITS - 1);
   localparam logic [CNT_BITS-1:0] CHAR_LAST = CNT_BITS'(CHAR_BITS - 1);

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_LENGTH = 3'b010,
      PH_CHARS  = 3'b100
   } phase_type;

   phase_type                phase_ff, phase_in;
   logic                     huff_ff, huff_in;
   logic [CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [CHAR_BITS-1:0]     shift_ff, shift_in;
   logic [CHAR_BITS-1:0]     left_ff, left_in;
   logic [NODE_IDX_BITS-1:0] pos_ff, pos_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic [NODE_BITS-1:0]     node_mem_ff [NODE_DEPTH];
   logic [NODE_BITS-1:0]     node_q_ff;   // entry of the node at pos_ff

   logic [CHILD_BITS-1:0]    child;
   logic [CHAR_BITS-1:0]     shift_set;
   logic                     emit;
   logic [CHAR_BITS-1:0]     emit_sym;
   logic                     res_hit;
   rsp_type                  res;
   logic                     wr_en;
   logic                     rd_ok;
   logic                     wr_hit;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      phase_in  = phase_ff;
      huff_in   = huff_ff;
      cnt_in    = cnt_ff;
      shift_in  = shift_ff;
      left_in   = left_ff;
      pos_in    = pos_ff;
      emit      = 1'b0;
      emit_sym  = '0;
      res_hit   = 1'b0;
      res       = '0;
      wr_en     = 1'b0;
      child     = cmd.stream_bit ? node_q_ff[NODE_BITS-1:CHILD_BITS]
                                 : node_q_ff[CHILD_BITS-1:0];
      shift_set = shift_ff | (CHAR_BITS'(cmd.stream_bit) << cnt_ff);

      if (cmd_pop) begin
         if (cmd.is_load) begin
            wr_en = cmd.wr_ok;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  huff_in  = cmd.stream_bit;
                  cnt_in   = '0;
                  shift_in = '0;
                  pos_in   = '0;
                  phase_in = PH_LENGTH;
               end
               PH_LENGTH: begin
                  shift_in = shift_set;
                  if (cnt_ff != LEN_LAST) begin
                     cnt_in = cnt_ff + 1'b1;
                  end else begin
                     left_in  = shift_set;
                     cnt_in   = '0;
                     shift_in = '0;
                     pos_in   = '0;
                     if (shift_set == '0) begin
                        phase_in         = PH_IDLE;
                        res_hit          = 1'b1;
                        res.last_char    = 1'b1;
                        res.empty_string = 1'b1;
                     end else begin
                        phase_in = PH_CHARS;
                     end
                  end
               end
               PH_CHARS: begin
                  if (!huff_ff) begin
                     if (cnt_ff != CHAR_LAST) begin
                        shift_in = shift_set;
                        cnt_in   = cnt_ff + 1'b1;
                     end else begin
                        cnt_in   = '0;
                        shift_in = '0;
                        emit     = 1'b1;
                        emit_sym = shift_set;
                     end
                  end else if (child[LEAF_BIT]) begin
                     pos_in   = '0;
                     emit     = 1'b1;
                     emit_sym = child[CHAR_BITS-1:0];
                  end else begin
                     pos_in = child[NODE_IDX_BITS-1:0];
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase

            if (emit) begin
               left_in       = left_ff - 1'b1;
               res_hit       = 1'b1;
               res.symbol    = emit_sym;
               res.last_char = (left_ff == CHAR_BITS'(1));
               if (left_ff == CHAR_BITS'(1)) begin
                  phase_in = PH_IDLE;
               end
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd_pop) begin
         rsp_valid_in = res_hit;
         rsp_data_in  = res;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         huff_ff      <= 1'b0;
         cnt_ff       <= '0;
         shift_ff     <= '0;
         left_ff      <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         huff_ff      <= huff_in;
         cnt_ff       <= cnt_in;
         shift_ff     <= shift_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // node table: read every cycle at the next walk position, a load to that
   // same node is forwarded so the prefetched entry never goes stale
   assign rd_ok  = ({1'b0, pos_in} < (NODE_IDX_BITS + 1)'(NODE_DEPTH));
   assign wr_hit = wr_en && (cmd.node_addr == pos_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem_ff[cmd.node_addr[AW-1:0]] <= cmd.node_data;
      end
      if (wr_hit) begin
         node_q_ff <= cmd.node_data;
      end else if (rd_ok) begin
         node_q_ff <= node_mem_ff[pos_in[AW-1:0]];
      end else begin
         node_q_ff <= '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_empty_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.empty_string) |->
         (rsp_data_ff.last_char && (rsp_data_ff.symbol == '0)))
      else $error("empty string result malformed");

   a_chars_left: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHARS) |-> (left_ff != '0))
      else $error("character phase with no characters left");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && res_hit && res.last_char) |=> (phase_ff == PH_IDLE))
      else $error("final character did not end the frame");
`endif

endmodule

[hdl/huffman_string_decoder_top.sv]
// top level of the huffman string decoder
// depends on hsd_pkg, hsd_front, hsd_queue and hsd_back

// usage
//  req channel: one transfer per item; op = 0 loads one tree node
//    {child_one, child_zero} at node_addr, op = 1 carries one stream bit
//  stream frame, lsb first: mode flag (1 huffman, 0 raw), LENGTH_BITS-bit
//    length, then the characters (8 bits raw, or a walk of the node table
//    from root node 0 until a leaf child)
//  rsp channel: one transfer per decoded character, last_char on the final
//    one; a zero length gives a single transfer with empty_string set
//  throughput: one item per cycle unless rsp stalls, set by the node table
//    prefetch that reads the next walk position every cycle with registered data
//  path: an accepted item is written into a four-entry queue, popped by the
//    back end, and its result is registered in the result register for rsp
//  rsp stall: the result register holds; the queue fills up to its four entries,
//    then req_stall rises
//  reset: clears the frame state, queue and result valid flag; the node table
//    is not cleared and must be loaded before use
module huffman_string_decoder_top
   import hsd_pkg::*;
#(
   parameter int NODE_DEPTH  = 256,
   parameter int LENGTH_BITS = 8
)(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type front_cmd;
   cmd_type head_cmd;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;

   // front: classify the request
   hsd_front #(
      .NODE_DEPTH (NODE_DEPTH)
   ) u_front (
      .req_data (req_data),
      .cmd      (front_cmd)
   );

   // stall only depends on the queue fill, never on req_valid
   assign req_stall = q_full;

   hsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_cmd  (front_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   // back: frame decode, node table and result register
   hsd_back #(
      .NODE_DEPTH  (NODE_DEPTH),
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (head_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
